>>> rtl/optical_flow_frame_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// Optical flow frame parser assertion macros
// Shared macros for the concurrent checks in the parser modules.
// ----------------------------------------------------------------------------
`ifndef OPTICAL_FLOW_FRAME_PARSER_UNIT_ASSERT_SVH
`define OPTICAL_FLOW_FRAME_PARSER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define OFP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define OFP_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define OFP_ASSERT(label, clk, rst, prop, msg)
`define OFP_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

>>> rtl/ofp_pkg.sv
// ----------------------------------------------------------------------------
// Optical flow frame parser package
// Types, frame constants and the quality scaling table shared by the parser.
// ----------------------------------------------------------------------------
package ofp_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [7:0] HEADER_BYTE = 8'hFE;
   localparam logic [7:0] FOOTER_BYTE = 8'hAA;
   localparam logic [7:0] QUAL_LOW    = 8'd64;
   localparam logic [7:0] QUAL_HIGH   = 8'd78;
   localparam logic [6:0] QUALITY_MAX = 7'd100;

   localparam int          FRAME_LEN   = 9;
   localparam logic [3:0]  POS_START   = 4'd0;
   localparam logic [3:0]  POS_LAST    = 4'(FRAME_LEN - 1);
   localparam logic [3:0]  POS_X_LO    = 4'd2;
   localparam logic [3:0]  POS_X_HI    = 4'd3;
   localparam logic [3:0]  POS_Y_LO    = 4'd4;
   localparam logic [3:0]  POS_Y_HI    = 4'd5;
   localparam logic [3:0]  POS_QUALITY = 4'd7;
   localparam logic [3:0]  POS_FOOTER  = 4'd8;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_POLL = 1'b1
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  pos;
      logic [7:0]  data;
      logic [31:0] time_us;
   } cmd_type;

   typedef struct packed {
      logic               new_data;
      logic [31:0]        delta_time_us;
      logic signed [31:0] flow_x;
      logic signed [31:0] flow_y;
      logic [6:0]         quality;
   } rsp_type;

   // Clamps the raw quality byte to the sensor range and scales it to percent.
   function automatic logic [6:0] scale_quality(input logic [7:0] raw);
      logic [7:0] clamped;
      logic [3:0] step;
      logic [6:0] pct;
      clamped = raw;
      if (raw < QUAL_LOW) begin
         clamped = QUAL_LOW;
      end else if (raw > QUAL_HIGH) begin
         clamped = QUAL_HIGH;
      end
      step = 4'(clamped - QUAL_LOW);
      case (step)
         4'd0:    pct = 7'd0;
         4'd1:    pct = 7'd7;
         4'd2:    pct = 7'd14;
         4'd3:    pct = 7'd21;
         4'd4:    pct = 7'd28;
         4'd5:    pct = 7'd35;
         4'd6:    pct = 7'd42;
         4'd7:    pct = 7'd50;
         4'd8:    pct = 7'd57;
         4'd9:    pct = 7'd64;
         4'd10:   pct = 7'd71;
         4'd11:   pct = 7'd78;
         4'd12:   pct = 7'd85;
         4'd13:   pct = 7'd92;
         4'd14:   pct = 7'd100;
         default: pct = 7'd100;
      endcase
      return pct;
   endfunction

endpackage

>>> rtl/optical_flow_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// Optical flow frame parser unit
// Parses 9-byte motion frames from a serial byte stream and reports on polls.
// ----------------------------------------------------------------------------
// The unit takes one word per clock on each side unless a full or empty queue
// stalls it. A word passes the front end in the cycle it is accepted, is
// registered in the command queue and is carried out by the back end; a
// poll's report is registered in the response queue, from which it is popped.
// The back end, which adds one frame's motion into the saturating sums, sets
// the unstalled rate of one word per clock; both queues hold QUEUE_DEPTH words.
module optical_flow_frame_parser_unit #(
   parameter int QUEUE_DEPTH = ofp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic               req_kind,
   input  logic [7:0]         req_byte_value,
   input  logic [31:0]        req_time_us,
   output logic               empty,
   input  logic               pop,
   output logic               rsp_new_data,
   output logic [31:0]        rsp_delta_time_us,
   output logic signed [31:0] rsp_flow_x,
   output logic signed [31:0] rsp_flow_y,
   output logic [6:0]         rsp_quality
);
   import ofp_pkg::*;

   cmd_type front_cmd, back_cmd;
   rsp_type back_rsp, out_rsp;
   logic    cmd_wr, cmd_full, cmd_rd, cmd_empty;
   logic    rsp_wr, rsp_full;

   ofp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_kind       (req_kind),
      .req_byte_value (req_byte_value),
      .req_time_us    (req_time_us),
      .cmd_full       (cmd_full),
      .cmd_wr         (cmd_wr),
      .cmd            (front_cmd)
   );

   ofp_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (cmd_wr),
      .wr_data (front_cmd),
      .full    (cmd_full),
      .rd      (cmd_rd),
      .rd_data (back_cmd),
      .empty   (cmd_empty)
   );

   ofp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd       (back_cmd),
      .cmd_rd    (cmd_rd),
      .rsp_full  (rsp_full),
      .rsp_wr    (rsp_wr),
      .rsp       (back_rsp)
   );

   ofp_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (rsp_wr),
      .wr_data (back_rsp),
      .full    (rsp_full),
      .rd      (pop),
      .rd_data (out_rsp),
      .empty   (empty)
   );

   assign rsp_new_data      = out_rsp.new_data;
   assign rsp_delta_time_us = out_rsp.delta_time_us;
   assign rsp_flow_x        = out_rsp.flow_x;
   assign rsp_flow_y        = out_rsp.flow_y;
   assign rsp_quality       = out_rsp.quality;

endmodule

>>> rtl/ofp_fifo.sv
// ----------------------------------------------------------------------------
// Optical flow frame parser queue
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
`include "optical_flow_frame_parser_unit_assert.svh"

module ofp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr && !full;
   assign do_rd   = rd && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `OFP_ASSERT(a_count_range, clock, reset, count_ff <= CNT_W'(DEPTH), "Queue count exceeds depth.")
   `OFP_ASSERT(a_count_wr, clock, reset, (do_wr && !do_rd) |=> count_ff == $past(count_ff) + 1'b1, "Queue count missed a write.")
   `OFP_ASSERT(a_ptr_match, clock, reset, (empty || full) |-> wr_ptr_ff == rd_ptr_ff, "Queue pointers disagree with count.")

endmodule

>>> rtl/ofp_front.sv
// ----------------------------------------------------------------------------
// Optical flow frame parser front end
// Accepts words, tracks the frame position and forwards useful bytes and polls.
// ----------------------------------------------------------------------------
`include "optical_flow_frame_parser_unit_assert.svh"

module ofp_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   output logic            full,
   input  logic            req_kind,
   input  logic [7:0]      req_byte_value,
   input  logic [31:0]     req_time_us,
   input  logic            cmd_full,
   output logic            cmd_wr,
   output ofp_pkg::cmd_type cmd
);
   import ofp_pkg::*;

   logic [3:0] pos_ff, pos_in;
   logic       accept;
   logic       is_byte;
   logic       drop;
   logic       keep;

   assign full    = cmd_full;
   assign accept  = push && !cmd_full;
   assign is_byte = (req_kind == 1'b0);
   assign drop    = is_byte && (pos_ff == POS_START) && (req_byte_value != HEADER_BYTE);

   always_comb begin
      case (pos_ff) inside
         POS_X_LO, POS_X_HI, POS_Y_LO, POS_Y_HI, POS_QUALITY, POS_FOOTER: keep = 1'b1;
         default: keep = 1'b0;
      endcase
   end

   always_comb begin
      pos_in = pos_ff;
      if (accept && is_byte && !drop) begin
         pos_in = (pos_ff == POS_LAST) ? POS_START : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_START;
      end else begin
         pos_ff <= pos_in;
      end
   end

   assign cmd_wr      = accept && (!is_byte || keep);
   assign cmd.op      = is_byte ? OP_BYTE : OP_POLL;
   assign cmd.pos     = pos_ff;
   assign cmd.data    = req_byte_value;
   assign cmd.time_us = req_time_us;

   `OFP_ASSERT(a_pos_range, clock, reset, pos_ff <= POS_LAST, "Frame position out of range.")
   `OFP_ASSERT(a_drop_idle, clock, reset, (accept && drop) |=> pos_ff == POS_START, "Dropped byte moved the frame position.")
   `OFP_ASSERT(a_poll_keeps_pos, clock, reset, (accept && !is_byte) |=> pos_ff == $past(pos_ff), "Poll moved the frame position.")

endmodule

>>> rtl/ofp_back.sv
// ----------------------------------------------------------------------------
// Optical flow frame parser back end
// Collects frame fields, accumulates motion and answers polls.
// ----------------------------------------------------------------------------
`include "optical_flow_frame_parser_unit_assert.svh"

module ofp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_empty,
   input  ofp_pkg::cmd_type cmd,
   output logic             cmd_rd,
   input  logic             rsp_full,
   output logic             rsp_wr,
   output ofp_pkg::rsp_type rsp
);
   import ofp_pkg::*;

   logic [7:0]         x_lo_ff, x_hi_ff, y_lo_ff, y_hi_ff, qual_raw_ff;
   logic signed [31:0] sum_x_ff, sum_x_in;
   logic signed [31:0] sum_y_ff, sum_y_in;
   logic [6:0]         quality_ff, quality_in;
   logic               pending_ff, pending_in;
   logic [31:0]        last_time_ff, last_time_in;
   logic               is_poll;
   logic               frame_ok;
   logic signed [31:0] delta_x, delta_y;
   logic [32:0]        wide_x, wide_y;

   function automatic logic signed [31:0] sat_sum(input logic [32:0] s);
      logic signed [31:0] r;
      r = s[31:0];
      if (s[32] != s[31]) begin
         r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

   assign is_poll  = (cmd.op == OP_POLL);
   assign cmd_rd   = !cmd_empty && (!is_poll || !rsp_full);
   assign rsp_wr   = cmd_rd && is_poll;
   assign frame_ok = cmd_rd && !is_poll && (cmd.pos == POS_FOOTER) && (cmd.data == FOOTER_BYTE);

   assign delta_x = {{16{x_hi_ff[7]}}, x_hi_ff, x_lo_ff};
   assign delta_y = {{16{y_hi_ff[7]}}, y_hi_ff, y_lo_ff};
   assign wide_x  = {sum_x_ff[31], sum_x_ff} + {delta_x[31], delta_x};
   assign wide_y  = {sum_y_ff[31], sum_y_ff} + {delta_y[31], delta_y};

   always_comb begin
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      quality_in   = quality_ff;
      pending_in   = pending_ff;
      last_time_in = last_time_ff;
      if (frame_ok) begin
         sum_x_in   = sat_sum(wide_x);
         sum_y_in   = sat_sum(wide_y);
         quality_in = scale_quality(qual_raw_ff);
         pending_in = 1'b1;
      end else if (rsp_wr && pending_ff) begin
         sum_x_in     = '0;
         sum_y_in     = '0;
         pending_in   = 1'b0;
         last_time_in = cmd.time_us;
      end
   end

   always_comb begin
      rsp = '0;
      if (pending_ff) begin
         rsp.new_data      = 1'b1;
         rsp.delta_time_us = cmd.time_us - last_time_ff;
         rsp.flow_x        = sum_x_ff;
         rsp.flow_y        = sum_y_ff;
         rsp.quality       = quality_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         quality_ff   <= '0;
         pending_ff   <= 1'b0;
         last_time_ff <= '0;
      end else begin
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         quality_ff   <= quality_in;
         pending_ff   <= pending_in;
         last_time_ff <= last_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_rd && !is_poll) begin
         case (cmd.pos)
            POS_X_LO:    x_lo_ff     <= cmd.data;
            POS_X_HI:    x_hi_ff     <= cmd.data;
            POS_Y_LO:    y_lo_ff     <= cmd.data;
            POS_Y_HI:    y_hi_ff     <= cmd.data;
            POS_QUALITY: qual_raw_ff <= cmd.data;
            default:     ;
         endcase
      end
   end

   `OFP_ASSERT(a_quality_range, clock, reset, quality_ff <= QUALITY_MAX, "Latched quality above full scale.")
   `OFP_ASSERT(a_report_clears, clock, reset, (rsp_wr && pending_ff) |=> (sum_x_ff == 0) && (sum_y_ff == 0) && !pending_ff, "Report did not clear the sums.")
   `OFP_ASSERT_NEVER(a_idle_report, clock, reset, rsp_wr && !pending_ff && (rsp.flow_x != 0 || rsp.quality != 0), "Empty report carries data.")

endmodule
